// ===== rtl/dqp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dqp_pkg
// Types and character constants for the dotted-quad address parser.
// ----------------------------------------------------------------------------
package dqp_pkg;

    // character codes
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // octet accumulator saturates at this value
    localparam int ACC_W = 9;
    localparam logic [ACC_W-1:0] OCTET_LIMIT = 9'd256;

    // widened width for accumulator * 10 + digit
    localparam int PROD_W = 13;

    localparam logic [1:0] LAST_OCTET = 2'd3;

    typedef logic [1:0]       octet_idx_t;
    typedef logic [ACC_W-1:0] octet_acc_t;
    typedef logic [23:0]      partial_addr_t;

endpackage : dqp_pkg
`default_nettype wire

// ===== rtl/dotted_quad_ipv4_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dotted_quad_ipv4_parser
// Parses a dotted-decimal IPv4 address text, one character per request.
// ----------------------------------------------------------------------------
// Accepts one character per clock cycle while s_ready is high; s_ready drops
// when a result waits on m_ready and the input register is full. Each request
// is caught in an input register, then decoded against the parse state
// (compare, multiply by ten as shift-add, saturate) and any result lands in
// an output register. The input side keeps taking characters while a result
// waits on m_ready, up to the single input register; a character with s_first
// high starts a new string, and the result is the address with the first octet
// in the high byte, or zero with m_success low on failure.
module dotted_quad_ipv4_parser
    import dqp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_first,
    input  wire logic [7:0]  s_ch,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_address,
    output logic             m_success
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic       in_first_reg;
    logic [7:0] in_ch_reg;

    // parse state
    octet_idx_t    idx_reg,  idx_next;
    octet_acc_t    acc_reg,  acc_next;
    partial_addr_t part_reg, part_next;
    logic          dec_reg,  dec_next;

    // result register
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   out_addr_reg;
    logic          out_ok_reg;

    logic          advance;
    logic          emit;
    logic [31:0]   emit_addr;
    logic          emit_ok;
    logic [PROD_W-1:0] prod;
    logic [3:0]    digit;
    octet_acc_t    acc_base;

    // decode moves when the result slot is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // a start mark clears the octet before its own digit is added
    assign acc_base = in_first_reg ? '0 : acc_reg;

    assign digit = in_ch_reg[3:0] - CH_ZERO[3:0];
    assign prod  = ({{(PROD_W-ACC_W){1'b0}}, acc_base} << 3)
                 + ({{(PROD_W-ACC_W){1'b0}}, acc_base} << 1)
                 + {{(PROD_W-4){1'b0}}, digit};

    // one parse step on the registered character
    always_comb begin
        idx_next  = idx_reg;
        acc_next  = acc_reg;
        part_next = part_reg;
        dec_next  = dec_reg;
        emit      = 1'b0;
        emit_addr = '0;
        emit_ok   = 1'b0;
        if (in_first_reg) begin
            idx_next  = '0;
            acc_next  = '0;
            part_next = '0;
            dec_next  = 1'b0;
        end
        if (!dec_next) begin
            if (in_ch_reg inside {[CH_ZERO:CH_NINE]}) begin
                if (prod > {{(PROD_W-ACC_W){1'b0}}, OCTET_LIMIT}) begin
                    acc_next = OCTET_LIMIT;
                end else begin
                    acc_next = prod[ACC_W-1:0];
                end
            end else if (idx_next != LAST_OCTET && in_ch_reg == CH_DOT) begin
                if (acc_next >= OCTET_LIMIT) begin
                    emit = 1'b1;
                end else begin
                    part_next = {part_next[15:0], acc_next[7:0]};
                    idx_next  = idx_next + 2'd1;
                    acc_next  = '0;
                end
            end else if (idx_next == LAST_OCTET) begin
                emit = 1'b1;
                if (acc_next < OCTET_LIMIT) begin
                    emit_addr = {part_next, acc_next[7:0]};
                    emit_ok   = 1'b1;
                end
            end else begin
                emit = 1'b1;
            end
            if (emit) begin
                dec_next = 1'b1;
            end
        end
    end

    // handshake next values
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance && emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            acc_reg       <= '0;
            part_reg      <= '0;
            dec_reg       <= 1'b1;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                idx_reg  <= idx_next;
                acc_reg  <= acc_next;
                part_reg <= part_next;
                dec_reg  <= dec_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_first_reg <= s_first;
            in_ch_reg    <= s_ch;
        end
        if (advance && emit) begin
            out_addr_reg <= emit_addr;
            out_ok_reg   <= emit_ok;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_address = out_addr_reg;
    assign m_success = out_ok_reg;

    // checks
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_success |-> m_address == 32'd0)
        else $error("failure result carries a nonzero address");

    a_acc_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg <= OCTET_LIMIT)
        else $error("octet accumulator above saturation limit");

    a_emit_decides: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && emit |=> dec_reg && m_valid)
        else $error("result issued without entering decided state");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_ch_reg)
            && $stable(in_first_reg))
        else $error("stalled character lost from input register");

endmodule : dotted_quad_ipv4_parser
`default_nettype wire
